FILE: rtl/cats_pkg.sv
package cats_pkg;

  // Coverage grid and run size
  localparam int AZ_BIN_COUNT = 36;
  localparam int EL_BIN_COUNT = 18;
  localparam int AZ_STEP_CDEG = 1000;
  localparam int EL_STEP_CDEG = 500;
  localparam int TARGET_SLOTS = 16;
  localparam int GRID_BINS    = AZ_BIN_COUNT * EL_BIN_COUNT;

  localparam int AZ_FULL_CDEG = 36000;
  localparam int EL_TOP_CDEG  = 9000;

  // Field and state widths
  localparam int FUNC_W  = 2;
  localparam int AZ_W    = 16;
  localparam int EL_W    = 15;
  localparam int SLOT_W  = $clog2(TARGET_SLOTS);
  localparam int RUN_W   = $clog2(TARGET_SLOTS + 1);
  localparam int COUNT_W = $clog2(GRID_BINS + 1);
  localparam int ROW_W   = $clog2(AZ_BIN_COUNT);
  localparam int COL_W   = $clog2(EL_BIN_COUNT);

  // Binning by reciprocal multiply: floor(x / step) = (x * recip) >> shift
  localparam int AZ_SHIFT   = 26;
  localparam int AZ_RECIP   = (2**AZ_SHIFT + AZ_STEP_CDEG - 1) / AZ_STEP_CDEG;
  localparam int AZ_RECIP_W = $clog2(AZ_RECIP + 1);
  localparam int AZ_PROD_W  = AZ_W + AZ_RECIP_W;
  localparam int AZ_Q_W     = AZ_PROD_W - AZ_SHIFT;

  localparam int EL_MAG_W   = EL_W - 1;
  localparam int EL_SHIFT   = 22;
  localparam int EL_RECIP   = (2**EL_SHIFT + EL_STEP_CDEG - 1) / EL_STEP_CDEG;
  localparam int EL_RECIP_W = $clog2(EL_RECIP + 1);
  localparam int EL_PROD_W  = EL_MAG_W + EL_RECIP_W;
  localparam int EL_Q_W     = EL_PROD_W - EL_SHIFT;

  // Register port
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 32;
  localparam int MIN_EL_RESET = 500;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_ELEVATION = '0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_OFFER = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef struct packed {
    logic              selected_valid;
    logic [SLOT_W-1:0] selected_index;
    logic              selected_unimaged;
    logic [COUNT_W-1:0] bins_done;
    logic              coverage_done;
  } result_t;

  // Item held in the stage register between input decode and the result stage
  typedef struct packed {
    logic                   vld;
    logic                   is_offer;
    logic                   is_mark;
    logic                   is_clear;
    logic                   last;
    logic                   consider;
    logic                   mark_ok;
    logic [SLOT_W-1:0]      slot;
    logic signed [EL_W-1:0] el;
    logic                   inr;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
  } stage_t;

endpackage

FILE: rtl/cats_in_if.sv
interface cats_in_if;
  logic                           valid;
  logic                           ready;
  logic [cats_pkg::FUNC_W-1:0]    func;
  logic [cats_pkg::AZ_W-1:0]      target_az;
  logic signed [cats_pkg::EL_W-1:0] target_el;
  logic                           last;
  logic [cats_pkg::SLOT_W-1:0]    target_index;

  modport source (output valid, func, target_az, target_el, last, target_index,
                  input ready);
  modport sink (input valid, func, target_az, target_el, last, target_index,
                output ready);
endinterface

FILE: rtl/cats_out_if.sv
interface cats_out_if;
  logic                          valid;
  logic                          ready;
  logic                          selected_valid;
  logic [cats_pkg::SLOT_W-1:0]   selected_index;
  logic                          selected_unimaged;
  logic [cats_pkg::COUNT_W-1:0]  bins_done;
  logic                          coverage_done;

  modport source (output valid, selected_valid, selected_index, selected_unimaged,
                  bins_done, coverage_done, input ready);
  modport sink (input valid, selected_valid, selected_index, selected_unimaged,
                bins_done, coverage_done, output ready);
endinterface

FILE: rtl/coverage_aware_target_selector_unit.sv
// Coverage-aware target selector. Takes one beat per clock: offers, marks and
// unused codes alike; a run's result is built in the result stage from its
// last offer, held in the stage register, and written to the result buffer.
// The coverage bitmap is a 36-row by 18-bit memory (one row per azimuth bin),
// wiped by a clearing pass over its rows. The pass runs straight out of reset,
// so in_chan.ready is low while it runs; after a clear beat it follows the
// beat's own cycle in the result stage, so ready is low from acceptance of a
// clear beat to the end of the pass (register writes are still taken).
// Results queue in a two-entry buffer, so input keeps flowing while a result
// waits to be taken; otherwise ready drops only when that buffer would overflow.
module coverage_aware_target_selector_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  cats_in_if.sink                         in_chan,
  cats_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cats_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cats_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cats_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import cats_pkg::*;

  // Configuration
  logic signed [EL_W-1:0] min_el_r;

  // Slot store and run tracking
  logic [ROW_W-1:0] slot_az_r  [TARGET_SLOTS];
  logic [COL_W-1:0] slot_el_r  [TARGET_SLOTS];
  logic             slot_inr_r [TARGET_SLOTS];
  logic [RUN_W-1:0] run_pos_r;

  // Running best
  logic                   best_found_r;
  logic [SLOT_W-1:0]      best_slot_r;
  logic                   best_unim_r;
  logic signed [EL_W-1:0] best_el_r;

  // Coverage memory, count and flag
  logic [EL_BIN_COUNT-1:0] cov_mem [AZ_BIN_COUNT];
  logic [EL_BIN_COUNT-1:0] mem_rd_r;
  logic [COUNT_W-1:0]      count_r;
  logic                    complete_r;
  logic                    sweep_r;
  logic [ROW_W-1:0]        sweep_cnt_r;

  // Last row written, forwarded to the next beat
  logic                    lw_vld_r;
  logic [ROW_W-1:0]        lw_row_r;
  logic [EL_BIN_COUNT-1:0] lw_data_r;

  stage_t s1_r, s1_nxt;

  // Result buffer
  result_t    fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fcnt_r;

  logic accept, pop, push, cfg_wr;
  logic [1:0] occ;

  func_t                 fn;
  logic [AZ_W-1:0]       az_wrap;
  logic [AZ_PROD_W-1:0]  az_prod;
  logic [AZ_Q_W-1:0]     az_q;
  logic [ROW_W-1:0]      az_bin;
  logic                  in_inr;
  logic [EL_MAG_W-1:0]   el_mag;
  logic [EL_PROD_W-1:0]  el_prod;
  logic [EL_Q_W-1:0]     el_q;
  logic [COL_W-1:0]      el_bin;
  logic                  stored;
  logic [ROW_W-1:0]      rd_row;

  logic [EL_BIN_COUNT-1:0] eff_row, new_row;
  logic                    hit, unim, take, mark_wr, mark_upd;
  logic                    fnd_n, unim_n;
  logic [SLOT_W-1:0]       slot_n;
  logic signed [EL_W-1:0]  el_n;
  logic [COUNT_W-1:0]      count_n;
  result_t                 res;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MIN_ELEVATION);
  assign prdata = (paddr == ADDR_MIN_ELEVATION) ?
                  {{(CFG_DATA_W-EL_W){min_el_r[EL_W-1]}}, min_el_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_el_r <= EL_W'(MIN_EL_RESET);
    end else if (cfg_wr) begin
      min_el_r <= pwdata[EL_W-1:0];
    end
  end

  // Handshake: hold off during clearing, behind a clear beat, or when the
  // result buffer could not take another result
  assign pop    = out_chan.valid && out_chan.ready;
  assign occ    = fcnt_r + {1'b0, push};
  assign in_chan.ready = !sweep_r && !(s1_r.vld && s1_r.is_clear) &&
                         ((occ <= 2'd1) || ((occ == 2'd2) && pop));
  assign accept = in_chan.valid && in_chan.ready;

  // Decode and binning of the incoming beat
  always_comb begin
    fn      = func_t'(in_chan.func);
    az_wrap = (in_chan.target_az >= AZ_W'(AZ_FULL_CDEG)) ?
              in_chan.target_az - AZ_W'(AZ_FULL_CDEG) : in_chan.target_az;
    az_prod = AZ_PROD_W'(az_wrap) * AZ_PROD_W'(AZ_RECIP);
    az_q    = az_prod[AZ_PROD_W-1:AZ_SHIFT];
    az_bin  = (az_q >= AZ_Q_W'(AZ_BIN_COUNT)) ? ROW_W'(AZ_BIN_COUNT - 1)
                                              : az_q[ROW_W-1:0];

    in_inr  = !in_chan.target_el[EL_W-1] &&
              (in_chan.target_el[EL_MAG_W-1:0] <= EL_MAG_W'(EL_TOP_CDEG));
    el_mag  = in_chan.target_el[EL_MAG_W-1:0];
    el_prod = EL_PROD_W'(el_mag) * EL_PROD_W'(EL_RECIP);
    el_q    = el_prod[EL_PROD_W-1:EL_SHIFT];
    if (!in_inr) begin
      el_bin = '0;
    end else if (el_q >= EL_Q_W'(EL_BIN_COUNT)) begin
      el_bin = COL_W'(EL_BIN_COUNT - 1);
    end else begin
      el_bin = el_q[COL_W-1:0];
    end

    stored = (fn == FUNC_OFFER) && (run_pos_r < RUN_W'(TARGET_SLOTS));

    s1_nxt          = '0;
    s1_nxt.vld      = accept;
    s1_nxt.is_offer = (fn == FUNC_OFFER);
    s1_nxt.is_mark  = (fn == FUNC_MARK);
    s1_nxt.is_clear = (fn == FUNC_CLEAR);
    s1_nxt.last     = in_chan.last;
    s1_nxt.consider = stored && (in_chan.target_el >= min_el_r);
    s1_nxt.mark_ok  = slot_inr_r[in_chan.target_index];
    s1_nxt.slot     = run_pos_r[SLOT_W-1:0];
    s1_nxt.el       = in_chan.target_el;
    s1_nxt.inr      = in_inr;
    if (fn == FUNC_MARK) begin
      s1_nxt.row = slot_az_r[in_chan.target_index];
      s1_nxt.col = slot_el_r[in_chan.target_index];
    end else begin
      s1_nxt.row = az_bin;
      s1_nxt.col = el_bin;
    end
    rd_row = s1_nxt.row;
  end

  // Slot store and run position, updated as each offer is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_pos_r <= '0;
      for (int i = 0; i < TARGET_SLOTS; i++) begin
        slot_az_r[i]  <= '0;
        slot_el_r[i]  <= '0;
        slot_inr_r[i] <= 1'b1;
      end
    end else if (accept && (fn == FUNC_OFFER)) begin
      if (stored) begin
        slot_az_r[run_pos_r[SLOT_W-1:0]]  <= az_bin;
        slot_el_r[run_pos_r[SLOT_W-1:0]]  <= el_bin;
        slot_inr_r[run_pos_r[SLOT_W-1:0]] <= in_inr;
      end
      if (in_chan.last) begin
        run_pos_r <= '0;
      end else if (stored) begin
        run_pos_r <= run_pos_r + RUN_W'(1);
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  // Result stage: bitmap lookup, best update, mark and result build
  always_comb begin
    eff_row = (lw_vld_r && (lw_row_r == s1_r.row)) ? lw_data_r : mem_rd_r;
    hit     = eff_row[s1_r.col];
    unim    = !(s1_r.inr && hit);
    take    = s1_r.vld && s1_r.is_offer && s1_r.consider &&
              (!best_found_r || (unim && !best_unim_r) ||
               ((unim == best_unim_r) && (s1_r.el > best_el_r)));
    fnd_n   = take ? 1'b1       : best_found_r;
    slot_n  = take ? s1_r.slot  : best_slot_r;
    unim_n  = take ? unim       : best_unim_r;
    el_n    = take ? s1_r.el    : best_el_r;

    mark_upd = s1_r.vld && s1_r.is_mark && s1_r.mark_ok;
    mark_wr  = mark_upd && !hit;
    new_row  = eff_row | (EL_BIN_COUNT'(1) << s1_r.col);
    count_n  = mark_wr ? count_r + COUNT_W'(1) : count_r;

    push = s1_r.vld && s1_r.is_offer && s1_r.last;
    res.selected_valid    = fnd_n && !complete_r;
    res.selected_index    = (fnd_n && !complete_r) ? slot_n : '0;
    res.selected_unimaged = fnd_n && !complete_r && unim_n;
    res.bins_done         = count_r;
    res.coverage_done     = complete_r;
  end

  // Running best; cleared when a run ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      best_slot_r  <= '0;
      best_unim_r  <= 1'b0;
      best_el_r    <= '0;
    end else if (push) begin
      best_found_r <= 1'b0;
      best_slot_r  <= '0;
      best_unim_r  <= 1'b0;
      best_el_r    <= '0;
    end else begin
      best_found_r <= fnd_n;
      best_slot_r  <= slot_n;
      best_unim_r  <= unim_n;
      best_el_r    <= el_n;
    end
  end

  // Count, flag, clearing pass and forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      complete_r  <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      lw_vld_r    <= 1'b0;
      lw_row_r    <= '0;
      lw_data_r   <= '0;
    end else if (s1_r.vld && s1_r.is_clear) begin
      count_r     <= '0;
      complete_r  <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      lw_vld_r    <= 1'b0;
    end else begin
      if (sweep_r) begin
        if (sweep_cnt_r == ROW_W'(AZ_BIN_COUNT - 1)) begin
          sweep_r <= 1'b0;
        end
        sweep_cnt_r <= sweep_cnt_r + ROW_W'(1);
      end
      if (mark_upd) begin
        count_r <= count_n;
        if (count_n >= COUNT_W'(GRID_BINS)) begin
          complete_r <= 1'b1;
        end
      end
      if (mark_wr) begin
        lw_vld_r  <= 1'b1;
        lw_row_r  <= s1_r.row;
        lw_data_r <= new_row;
      end
    end
  end

  // Coverage memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (sweep_r) begin
      cov_mem[sweep_cnt_r] <= '0;
    end else if (mark_wr) begin
      cov_mem[s1_r.row] <= new_row;
    end
    mem_rd_r <= cov_mem[rd_row];
  end

  // Result buffer, two entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fcnt_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fcnt_r <= fcnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
  end

  assign out_chan.valid             = (fcnt_r != 2'd0);
  assign out_chan.selected_valid    = fifo_r[rd_ptr_r].selected_valid;
  assign out_chan.selected_index    = fifo_r[rd_ptr_r].selected_index;
  assign out_chan.selected_unimaged = fifo_r[rd_ptr_r].selected_unimaged;
  assign out_chan.bins_done         = fifo_r[rd_ptr_r].bins_done;
  assign out_chan.coverage_done     = fifo_r[rd_ptr_r].coverage_done;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cats_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES   = 48;   // clearing pass plus result stage
  localparam int MAX_REPORTS     = 10;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cats_in_if  in_chan ();
  cats_out_if out_chan ();

  coverage_aware_target_selector_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Coverage and run state as the selector should hold it
  bit                cov_map [GRID_BINS];
  int unsigned       imaged_bins;
  bit                all_imaged;
  logic [ROW_W-1:0]  slot_row [TARGET_SLOTS];
  logic [COL_W-1:0]  slot_col [TARGET_SLOTS];
  bit                slot_el_ok [TARGET_SLOTS];
  int unsigned       run_pos;
  bit                have_best;
  bit                best_fresh;
  logic [SLOT_W-1:0] best_pos;
  int                best_el;
  int                min_el_cdeg;

  result_t pending_picks [$];

  int errors;
  int beats_in;
  int picks_checked;
  int picks_full;
  int idle_cycles;
  bit gaps_on;
  bit hold_request;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void clear_cov_model();
    foreach (cov_map[i]) cov_map[i] = 1'b0;
    imaged_bins = 0;
    all_imaged  = 1'b0;
  endfunction

  function automatic void reset_run();
    run_pos    = 0;
    have_best  = 1'b0;
    best_pos   = '0;
    best_fresh = 1'b0;
    best_el    = 0;
  endfunction

  // Fold one accepted beat into the selector state; queue a result on last offer
  function automatic void predict_selection(input logic [FUNC_W-1:0] f,
                                            input logic [AZ_W-1:0] az,
                                            input logic signed [EL_W-1:0] el_in,
                                            input logic last,
                                            input logic [SLOT_W-1:0] idx);
    int      el;
    int      row;
    int      col;
    int      addr;
    bit      inr;
    bit      fresh;
    result_t pick;
    el = el_in;
    case (f)
      FUNC_MARK: begin
        if (slot_el_ok[idx]) begin
          addr = int'(slot_row[idx]) * EL_BIN_COUNT + int'(slot_col[idx]);
          if (addr < GRID_BINS && !cov_map[addr]) begin
            cov_map[addr] = 1'b1;
            imaged_bins++;
          end
          if (imaged_bins >= GRID_BINS) all_imaged = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        clear_cov_model();
      end
      FUNC_OFFER: begin
        if (run_pos < TARGET_SLOTS) begin
          row = (int'(az) % AZ_FULL_CDEG) / AZ_STEP_CDEG;
          if (row >= AZ_BIN_COUNT) row = AZ_BIN_COUNT - 1;
          inr = (el >= 0) && (el <= EL_TOP_CDEG);
          col = inr ? el / EL_STEP_CDEG : 0;
          if (col >= EL_BIN_COUNT) col = EL_BIN_COUNT - 1;
          slot_row[run_pos]   = ROW_W'(row);
          slot_col[run_pos]   = COL_W'(col);
          slot_el_ok[run_pos] = inr;
          // visible: unimaged first, then strictly higher elevation
          if (el >= min_el_cdeg) begin
            addr  = row * EL_BIN_COUNT + col;
            fresh = !(inr && cov_map[addr]);
            if (!have_best || (fresh && !best_fresh) ||
                (fresh == best_fresh && el > best_el)) begin
              have_best  = 1'b1;
              best_pos   = SLOT_W'(run_pos);
              best_fresh = fresh;
              best_el    = el;
            end
          end
          run_pos++;
        end
        if (last) begin
          pick.selected_valid    = have_best && !all_imaged;
          pick.selected_index    = pick.selected_valid ? best_pos : '0;
          pick.selected_unimaged = pick.selected_valid && best_fresh;
          pick.bins_done         = COUNT_W'(imaged_bins);
          pick.coverage_done     = all_imaged;
          pending_picks.push_back(pick);
          reset_run();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_selection(input result_t got);
    result_t want;
    if (pending_picks.size() == 0) begin
      note_mismatch($sformatf("Result beat with nothing expected: valid %0b index %0d",
                              got.selected_valid, got.selected_index));
      return;
    end
    want = pending_picks.pop_front();
    picks_checked++;
    if (want.coverage_done) picks_full++;
    if (got.selected_valid !== want.selected_valid ||
        got.selected_index !== want.selected_index ||
        got.selected_unimaged !== want.selected_unimaged ||
        got.bins_done !== want.bins_done ||
        got.coverage_done !== want.coverage_done) begin
      note_mismatch($sformatf({"Selection %0d: expected valid %0b index %0d unimaged %0b ",
                               "bins %0d done %0b, got valid %0b index %0d unimaged %0b ",
                               "bins %0d done %0b"}, picks_checked,
                              want.selected_valid, want.selected_index,
                              want.selected_unimaged, want.bins_done, want.coverage_done,
                              got.selected_valid, got.selected_index,
                              got.selected_unimaged, got.bins_done, got.coverage_done));
    end
  endfunction

  // Beats in and out, sampled at the rising edge
  always @(posedge clk) begin : beat_monitor
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        predict_selection(in_chan.func, in_chan.target_az, in_chan.target_el,
                          in_chan.last, in_chan.target_index);
        beats_in++;
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        got.selected_valid    = out_chan.selected_valid;
        got.selected_index    = out_chan.selected_index;
        got.selected_unimaged = out_chan.selected_unimaged;
        got.bins_done         = out_chan.bins_done;
        got.coverage_done     = out_chan.coverage_done;
        check_selection(got);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_picks.size());
    $display("Some tests failed");
    $finish;
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // One input beat, held until accepted
  task automatic send_beat(input logic [FUNC_W-1:0] f, input int az, input int el,
                           input bit last, input int idx);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.func         <= f;
    in_chan.target_az    <= AZ_W'(az);
    in_chan.target_el    <= EL_W'(el);
    in_chan.last         <= last;
    in_chan.target_index <= SLOT_W'(idx);
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drain all results, then let marks and clears work through
  task automatic wait_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input int value);
    logic signed [EL_W-1:0] el_val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    el_val      = value[EL_W-1:0];
    min_el_cdeg = el_val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr,
                          output logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int pick_az();
    int sel;
    sel = $urandom_range(0, 9);
    // half the time rows 0 to 3 only, so that marked bins come round again
    if (sel < 5) return $urandom_range(0, 3999);
    if (sel < 9) return $urandom_range(0, AZ_FULL_CDEG - 1);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int pick_el();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 1999);
    if (sel < 8) return int'($urandom_range(0, 2 * EL_TOP_CDEG)) - EL_TOP_CDEG;
    if (sel == 8) begin
      case ($urandom_range(0, 5))
        0: return min_el_cdeg;
        1: return min_el_cdeg - 1;
        2: return 0;
        3: return -1;
        4: return EL_TOP_CDEG;
        default: return EL_TOP_CDEG + 1;
      endcase
    end
    return int'($urandom_range(0, 32767)) - 16384;
  endfunction

  task automatic test_register_access();
    logic [CFG_DATA_W-1:0] rd;
    int                    vals [3];
    cfg_read(ADDR_MIN_ELEVATION, rd);
    if (rd[EL_W-1:0] !== EL_W'(MIN_EL_RESET)) begin
      note_mismatch($sformatf("min elevation after reset: expected %0d, read 0x%h",
                              MIN_EL_RESET, rd));
    end
    vals = '{EL_TOP_CDEG, -EL_TOP_CDEG, MIN_EL_RESET};
    foreach (vals[i]) begin
      cfg_write(ADDR_MIN_ELEVATION, vals[i]);
      cfg_read(ADDR_MIN_ELEVATION, rd);
      if (rd[EL_W-1:0] !== vals[i][EL_W-1:0]) begin
        note_mismatch($sformatf("min elevation read back: expected %0d, read 0x%h",
                                vals[i], rd));
      end
    end
  endtask

  task automatic test_directed();
    // slots start in range at bin 0, so a mark straight after reset images it
    send_beat(FUNC_MARK, 0, 0, 1'b0, 15);
    send_beat(FUNC_OFFER, 100, 600, 1'b1, 0);
    send_beat(FUNC_MARK, 0, 0, 1'b0, 0);
    // below threshold, imaged, unimaged lower, extremes, equal elevation tie
    send_beat(FUNC_OFFER, 500, 499, 1'b0, 0);
    send_beat(FUNC_OFFER, 500, 700, 1'b0, 0);
    send_beat(FUNC_OFFER, 1000, 600, 1'b0, 0);
    send_beat(FUNC_OFFER, 35999, EL_TOP_CDEG, 1'b0, 0);
    send_beat(FUNC_OFFER, 65535, EL_TOP_CDEG, 1'b0, 0);
    send_beat(FUNC_OFFER, 0, 16383, 1'b0, 0);
    send_beat(FUNC_OFFER, 0, -16384, 1'b1, 0);
    // out-of-range slot is ignored, in-range one counts
    send_beat(FUNC_MARK, 0, 0, 1'b0, 5);
    send_beat(FUNC_MARK, 0, 0, 1'b0, 3);
    send_beat(FUNC_UNUSED, 35999, -1, 1'b1, 15);
    // run longer than the slot store
    for (int k = 0; k <= TARGET_SLOTS; k++) begin
      send_beat(FUNC_OFFER, (k * 2250) % AZ_FULL_CDEG, 1000 + k * 400,
                k == TARGET_SLOTS, 0);
    end
    send_beat(FUNC_CLEAR, 0, 0, 1'b0, 0);
    send_beat(FUNC_OFFER, 100, 600, 1'b1, 0);
    wait_idle();
  endtask

  // Image every bin through offers and marks, then probe the complete state
  task automatic test_coverage_fill();
    int bin_order [GRID_BINS];
    int slot_order [TARGET_SLOTS];
    int runs;
    int j;
    int swap;
    int b;
    cfg_write(ADDR_MIN_ELEVATION, -EL_TOP_CDEG);
    foreach (bin_order[i]) bin_order[i] = i;
    for (int i = GRID_BINS - 1; i > 0; i--) begin
      j            = $urandom_range(0, i);
      swap         = bin_order[i];
      bin_order[i] = bin_order[j];
      bin_order[j] = swap;
    end
    runs = (GRID_BINS + TARGET_SLOTS - 1) / TARGET_SLOTS;
    for (int r = 0; r < runs; r++) begin
      for (int k = 0; k < TARGET_SLOTS; k++) begin
        b = bin_order[(r * TARGET_SLOTS + k) % GRID_BINS];
        send_beat(FUNC_OFFER,
                  (b / EL_BIN_COUNT) * AZ_STEP_CDEG + $urandom_range(0, AZ_STEP_CDEG - 1),
                  (b % EL_BIN_COUNT) * EL_STEP_CDEG + $urandom_range(0, EL_STEP_CDEG - 1),
                  k == TARGET_SLOTS - 1, 0);
      end
      foreach (slot_order[i]) slot_order[i] = i;
      for (int i = TARGET_SLOTS - 1; i > 0; i--) begin
        j             = $urandom_range(0, i);
        swap          = slot_order[i];
        slot_order[i] = slot_order[j];
        slot_order[j] = swap;
      end
      foreach (slot_order[i]) begin
        send_beat(FUNC_MARK, 0, 0, 1'b0, slot_order[i]);
      end
    end
    // complete: nothing chosen, flag stays set on a further mark and drops on a clear
    send_beat(FUNC_OFFER, pick_az(), pick_el(), 1'b0, 0);
    send_beat(FUNC_OFFER, pick_az(), pick_el(), 1'b1, 0);
    send_beat(FUNC_MARK, 0, 0, 1'b0, 0);
    send_beat(FUNC_OFFER, pick_az(), 4000, 1'b1, 0);
    send_beat(FUNC_CLEAR, 0, 0, 1'b0, 0);
    send_beat(FUNC_OFFER, pick_az(), 4000, 1'b1, 0);
    wait_idle();
  endtask

  // Output held off while short runs keep arriving
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (12) begin
      send_beat(FUNC_OFFER, pick_az(), $urandom_range(0, EL_TOP_CDEG), 1'b1, 0);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_beats, input int min_el);
    int kind;
    int len_left;
    cfg_write(ADDR_MIN_ELEVATION, min_el);
    len_left = 0;
    repeat (n_beats) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        if (len_left == 0) begin
          len_left = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                  : $urandom_range(1, 16);
        end
        len_left--;
        send_beat(FUNC_OFFER, pick_az(), pick_el(), len_left == 0, $urandom_range(0, 15));
      end else if (kind < 93) begin
        send_beat(FUNC_MARK, $urandom_range(0, 65535), pick_el(), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 15));
      end else if (kind < 96) begin
        send_beat(FUNC_CLEAR, $urandom_range(0, 65535), pick_el(), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 15));
      end else begin
        send_beat(FUNC_UNUSED, $urandom_range(0, 65535), pick_el(), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 15));
      end
    end
    wait_idle();
  endtask

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.func         = FUNC_OFFER;
    in_chan.target_az    = '0;
    in_chan.target_el    = '0;
    in_chan.last         = 1'b0;
    in_chan.target_index = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    beats_in      = 0;
    picks_checked = 0;
    picks_full    = 0;
    gaps_on       = 1'b1;
    hold_request  = 1'b0;

    // predictor reset state
    clear_cov_model();
    foreach (slot_row[i]) begin
      slot_row[i]   = '0;
      slot_col[i]   = '0;
      slot_el_ok[i] = 1'b1;
    end
    reset_run();
    min_el_cdeg = MIN_EL_RESET;

    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed();
    test_coverage_fill();
    test_backpressure();
    test_random_traffic(200, EL_TOP_CDEG);
    test_random_traffic(200, int'($urandom_range(0, 2 * EL_TOP_CDEG)) - EL_TOP_CDEG);
    test_random_traffic(200, 0);
    gaps_on = 1'b0;
    test_random_traffic(200, MIN_EL_RESET);

    $display("Run covered %0d input beats and %0d selections, %0d with coverage complete.",
             beats_in, picks_checked, picks_full);
    $display("Threshold swept across its range; idling, output hold-off and a gapless tail.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
